[rtl/dlse_pkg.sv]
// Package for the dual LIFO stack engine: sizes, operation and status codes,
// and the command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package dlse_pkg;

  // Storage geometry: two stacks of DEPTH elements each, sharing one memory.
  localparam int DEPTH     = 256;
  localparam int ELEM_W    = 32;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = PTR_W + 1;
  localparam int ADDR_W    = PTR_W + 1;
  localparam int MEM_DEPTH = 2 * DEPTH;

  // Fixed field widths of the interface.
  localparam int CAP_W     = 9;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 9;
  localparam int IN_USER_W = 4;
  localparam int OUT_W     = 48;

  // Configuration register indexes.
  localparam logic CFG_CAP_FIRST  = 1'b0;
  localparam logic CFG_CAP_SECOND = 1'b1;

  // Capacity registers come out of reset at the full depth of a stack.
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [2:0] {
    FUNC_PUSH     = 3'd0,
    FUNC_POP      = 3'd1,
    FUNC_TOP      = 3'd2,
    FUNC_CLEAR    = 3'd3,
    FUNC_REVERSE  = 3'd4,
    FUNC_MOVE_TOP = 3'd5,
    FUNC_APPEND   = 3'd6,
    FUNC_OVERTURN = 3'd7
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_NO_ROOM = 2'd2
  } status_e;

  // Memory access requested by the controller for the current cycle.
  typedef enum logic [3:0] {
    MEM_NONE,
    MEM_PUSH,
    MEM_RD_DTOP,
    MEM_RD_STOP,
    MEM_MOVE_WR,
    MEM_REV_RD_LO,
    MEM_REV_RD_HI,
    MEM_REV_WR_HI,
    MEM_REV_WR_LO,
    MEM_XFER_RD,
    MEM_XFER_WR
  } mem_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD_WAIT,
    ST_MOVE_WR,
    ST_REV_RD_LO,
    ST_REV_RD_HI,
    ST_REV_WR_HI,
    ST_REV_WR_LO,
    ST_XFER_RD,
    ST_XFER_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    latch_op;
    logic    set_status;
    status_e status;
    mem_op_e mem_op;
    logic    clear_dc;
    logic    pop_dec;
    logic    latch_rv;
    logic    rev_init;
    logic    xfer_init;
    logic    xfer_fin;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  dst_full;
    logic  dst_empty;
    logic  src_empty;
    logic  no_room;
    logic  rev_long;
    logic  rev_more;
    logic  xfer_last;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/dlse_ctrl.sv]
// Controller of the dual LIFO stack engine: the operation sequencer.
// Depends on dlse_pkg for the state, command and status types.
`default_nettype none

module dlse_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dlse_pkg::stat_t stat_i,
  output dlse_pkg::cmd_t      cmd_o
);

  dlse_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlse_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dlse_pkg::ST_DECIDE;
      end
      dlse_pkg::ST_DECIDE: begin
        unique case (stat_i.func)
          dlse_pkg::FUNC_PUSH, dlse_pkg::FUNC_CLEAR: begin
            state_d = dlse_pkg::ST_DONE;
          end
          dlse_pkg::FUNC_POP, dlse_pkg::FUNC_TOP: begin
            state_d = stat_i.dst_empty ? dlse_pkg::ST_DONE : dlse_pkg::ST_RD_WAIT;
          end
          dlse_pkg::FUNC_REVERSE: begin
            state_d = stat_i.rev_long ? dlse_pkg::ST_REV_RD_LO : dlse_pkg::ST_DONE;
          end
          dlse_pkg::FUNC_MOVE_TOP: begin
            state_d = (stat_i.src_empty || stat_i.dst_full) ? dlse_pkg::ST_DONE
                                                            : dlse_pkg::ST_MOVE_WR;
          end
          dlse_pkg::FUNC_APPEND, dlse_pkg::FUNC_OVERTURN: begin
            state_d = (stat_i.src_empty || stat_i.no_room) ? dlse_pkg::ST_DONE
                                                           : dlse_pkg::ST_XFER_RD;
          end
          default: state_d = dlse_pkg::ST_DONE;
        endcase
      end
      dlse_pkg::ST_RD_WAIT:   state_d = dlse_pkg::ST_DONE;
      dlse_pkg::ST_MOVE_WR:   state_d = dlse_pkg::ST_DONE;
      dlse_pkg::ST_REV_RD_LO: state_d = dlse_pkg::ST_REV_RD_HI;
      dlse_pkg::ST_REV_RD_HI: state_d = dlse_pkg::ST_REV_WR_HI;
      dlse_pkg::ST_REV_WR_HI: state_d = dlse_pkg::ST_REV_WR_LO;
      dlse_pkg::ST_REV_WR_LO: begin
        state_d = stat_i.rev_more ? dlse_pkg::ST_REV_RD_LO : dlse_pkg::ST_DONE;
      end
      dlse_pkg::ST_XFER_RD:   state_d = dlse_pkg::ST_XFER_WR;
      dlse_pkg::ST_XFER_WR: begin
        state_d = stat_i.xfer_last ? dlse_pkg::ST_DONE : dlse_pkg::ST_XFER_RD;
      end
      dlse_pkg::ST_DONE: begin
        // The result leaves for the output register; the next item may enter.
        if (stat_i.out_free) begin
          state_d = in_valid_i ? dlse_pkg::ST_DECIDE : dlse_pkg::ST_IDLE;
        end
      end
      default: state_d = dlse_pkg::ST_IDLE;
    endcase
  end

  // Commands and the input ready.
  always_comb begin
    cmd_o      = '0;
    cmd_o.status = dlse_pkg::STS_OK;
    cmd_o.mem_op = dlse_pkg::MEM_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      dlse_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_op = in_valid_i;
      end
      dlse_pkg::ST_DECIDE: begin
        cmd_o.set_status = 1'b1;
        unique case (stat_i.func)
          dlse_pkg::FUNC_PUSH: begin
            if (stat_i.dst_full) begin
              cmd_o.status = dlse_pkg::STS_NO_ROOM;
            end else begin
              cmd_o.mem_op = dlse_pkg::MEM_PUSH;
            end
          end
          dlse_pkg::FUNC_POP, dlse_pkg::FUNC_TOP: begin
            if (stat_i.dst_empty) begin
              cmd_o.status = dlse_pkg::STS_EMPTY;
            end else begin
              cmd_o.mem_op = dlse_pkg::MEM_RD_DTOP;
            end
          end
          dlse_pkg::FUNC_CLEAR: cmd_o.clear_dc = 1'b1;
          dlse_pkg::FUNC_REVERSE: cmd_o.rev_init = 1'b1;
          dlse_pkg::FUNC_MOVE_TOP: begin
            if (stat_i.src_empty) begin
              cmd_o.status = dlse_pkg::STS_EMPTY;
            end else if (stat_i.dst_full) begin
              cmd_o.status = dlse_pkg::STS_NO_ROOM;
            end else begin
              cmd_o.mem_op = dlse_pkg::MEM_RD_STOP;
            end
          end
          dlse_pkg::FUNC_APPEND, dlse_pkg::FUNC_OVERTURN: begin
            if (stat_i.src_empty) begin
              cmd_o.status = dlse_pkg::STS_EMPTY;
            end else if (stat_i.no_room) begin
              cmd_o.status = dlse_pkg::STS_NO_ROOM;
            end else begin
              cmd_o.xfer_init = 1'b1;
            end
          end
          default: cmd_o.status = dlse_pkg::STS_OK;
        endcase
      end
      dlse_pkg::ST_RD_WAIT: begin
        cmd_o.latch_rv = 1'b1;
        cmd_o.pop_dec  = (stat_i.func == dlse_pkg::FUNC_POP);
      end
      dlse_pkg::ST_MOVE_WR:   cmd_o.mem_op = dlse_pkg::MEM_MOVE_WR;
      dlse_pkg::ST_REV_RD_LO: cmd_o.mem_op = dlse_pkg::MEM_REV_RD_LO;
      dlse_pkg::ST_REV_RD_HI: cmd_o.mem_op = dlse_pkg::MEM_REV_RD_HI;
      dlse_pkg::ST_REV_WR_HI: cmd_o.mem_op = dlse_pkg::MEM_REV_WR_HI;
      dlse_pkg::ST_REV_WR_LO: cmd_o.mem_op = dlse_pkg::MEM_REV_WR_LO;
      dlse_pkg::ST_XFER_RD:   cmd_o.mem_op = dlse_pkg::MEM_XFER_RD;
      dlse_pkg::ST_XFER_WR: begin
        cmd_o.mem_op   = dlse_pkg::MEM_XFER_WR;
        cmd_o.xfer_fin = stat_i.xfer_last;
      end
      dlse_pkg::ST_DONE: begin
        cmd_o.load_out = stat_i.out_free;
        in_ready_o     = stat_i.out_free;
        cmd_o.latch_op = stat_i.out_free && in_valid_i;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/dlse_datapath.sv]
// Datapath of the dual LIFO stack engine: element memory, stack counts,
// capacity registers, walk pointers and the result register.
// Depends on dlse_pkg; driven by commands from dlse_ctrl.
`default_nettype none

module dlse_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [dlse_pkg::CAP_W-1:0]       cfg_wdata_i,
  // Input payload.
  input  wire logic [dlse_pkg::VALUE_W-1:0]     in_data_i,
  input  wire logic [dlse_pkg::IN_USER_W-1:0]   in_user_i,
  // Output channel.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [dlse_pkg::OUT_W-1:0]            out_data_o,
  // Controller link.
  input  wire dlse_pkg::cmd_t                   cmd_i,
  output dlse_pkg::stat_t                       stat_o
);

  localparam int PTR_W  = dlse_pkg::PTR_W;
  localparam int CNT_W  = dlse_pkg::CNT_W;
  localparam int ELEM_W = dlse_pkg::ELEM_W;

  // Latched operation.
  dlse_pkg::func_e     op_func_q;
  logic                op_sel_q;
  logic [ELEM_W-1:0]   op_pv_q;

  // Stack state and configuration.
  logic [CNT_W-1:0]          cnt_q [2];
  logic [CNT_W-1:0]          cnt_d [2];
  logic [dlse_pkg::CAP_W-1:0] cap_q [2];

  // Walk pointers, element buffers and result.
  logic [PTR_W-1:0]    lo_q, hi_q, idx_q;
  logic [ELEM_W-1:0]   tmp_q, rd_data_q;
  dlse_pkg::status_e   res_status_q;
  logic [dlse_pkg::VALUE_W-1:0] res_rv_q;

  // Output register.
  logic                         out_valid_q;
  dlse_pkg::status_e            out_status_q;
  logic [dlse_pkg::VALUE_W-1:0] out_rv_q;
  logic                         out_empty_q;
  logic [dlse_pkg::COUNT_W-1:0] out_count_q;

  // Element memory.
  logic [ELEM_W-1:0]            mem [dlse_pkg::MEM_DEPTH];
  logic                         mem_we, mem_re;
  logic [dlse_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ELEM_W-1:0]            mem_wdata;

  // Derived quantities of the addressed (destination) and other (source) stack.
  logic              src_sel;
  logic [CNT_W-1:0]  dc, sc, dcap, dc_m1, sc_m1, dc_p1, room;
  logic [PTR_W-1:0]  from_ptr;
  logic [CNT_W-1:0]  xfer_addr;

  assign src_sel = ~op_sel_q;
  assign dc      = cnt_q[op_sel_q];
  assign sc      = cnt_q[src_sel];
  assign dc_m1   = dc - CNT_W'(1);
  assign sc_m1   = sc - CNT_W'(1);
  assign dc_p1   = dc + CNT_W'(1);
  assign room    = dcap - dc;

  // Effective capacity: the register saturated at the stack depth.
  always_comb begin
    if (32'(cap_q[op_sel_q]) > dlse_pkg::DEPTH) begin
      dcap = CNT_W'(dlse_pkg::DEPTH);
    end else begin
      dcap = CNT_W'(cap_q[op_sel_q]);
    end
  end

  // Append copies bottom up; overturn reads the source from its top down.
  assign from_ptr  = (op_func_q == dlse_pkg::FUNC_APPEND) ? idx_q
                                                         : sc_m1[PTR_W-1:0] - idx_q;
  assign xfer_addr = dc + CNT_W'(idx_q);

  // Status towards the controller.
  always_comb begin
    stat_o.func      = op_func_q;
    stat_o.dst_full  = (dc >= dcap);
    stat_o.dst_empty = (dc == '0);
    stat_o.src_empty = (sc == '0);
    stat_o.no_room   = (dc > dcap) || (sc > room);
    stat_o.rev_long  = (dc > CNT_W'(1));
    stat_o.rev_more  = ({1'b0, lo_q} + CNT_W'(2)) < {1'b0, hi_q};
    stat_o.xfer_last = (idx_q == sc_m1[PTR_W-1:0]);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {op_sel_q, dc[PTR_W-1:0]};
    mem_raddr = {op_sel_q, lo_q};
    mem_wdata = rd_data_q;
    unique case (cmd_i.mem_op)
      dlse_pkg::MEM_NONE: mem_we = 1'b0;
      dlse_pkg::MEM_PUSH: begin
        mem_we    = 1'b1;
        mem_wdata = op_pv_q;
      end
      dlse_pkg::MEM_RD_DTOP: begin
        mem_re    = 1'b1;
        mem_raddr = {op_sel_q, dc_m1[PTR_W-1:0]};
      end
      dlse_pkg::MEM_RD_STOP: begin
        mem_re    = 1'b1;
        mem_raddr = {src_sel, sc_m1[PTR_W-1:0]};
      end
      dlse_pkg::MEM_MOVE_WR: mem_we = 1'b1;
      dlse_pkg::MEM_REV_RD_LO: mem_re = 1'b1;
      dlse_pkg::MEM_REV_RD_HI: begin
        mem_re    = 1'b1;
        mem_raddr = {op_sel_q, hi_q};
      end
      dlse_pkg::MEM_REV_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = {op_sel_q, hi_q};
        mem_wdata = tmp_q;
      end
      dlse_pkg::MEM_REV_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = {op_sel_q, lo_q};
        mem_wdata = tmp_q;
      end
      dlse_pkg::MEM_XFER_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {src_sel, from_ptr};
      end
      dlse_pkg::MEM_XFER_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {op_sel_q, xfer_addr[PTR_W-1:0]};
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Element memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Next stack counts.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_dc) begin
      cnt_d[op_sel_q] = '0;
    end
    if (cmd_i.mem_op == dlse_pkg::MEM_PUSH) begin
      cnt_d[op_sel_q] = dc_p1;
    end
    if (cmd_i.pop_dec) begin
      cnt_d[op_sel_q] = dc_m1;
    end
    if (cmd_i.mem_op == dlse_pkg::MEM_MOVE_WR) begin
      cnt_d[op_sel_q] = dc_p1;
      cnt_d[src_sel]  = sc_m1;
    end
    if (cmd_i.xfer_fin) begin
      cnt_d[op_sel_q] = dc + sc;
      cnt_d[src_sel]  = '0;
    end
  end

  // Control state: counts, capacities and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      cap_q[0]    <= dlse_pkg::CAP_RESET;
      cap_q[1]    <= dlse_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i && (cfg_index_i == dlse_pkg::CFG_CAP_FIRST)) begin
        cap_q[0] <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == dlse_pkg::CFG_CAP_SECOND)) begin
        cap_q[1] <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: operation, walk pointers, result and output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_op) begin
      op_func_q <= dlse_pkg::func_e'(in_user_i[2:0]);
      op_sel_q  <= in_user_i[3];
      op_pv_q   <= ELEM_W'(in_data_i);
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
      res_rv_q     <= '0;
    end
    if (cmd_i.latch_rv) begin
      res_rv_q <= dlse_pkg::VALUE_W'(rd_data_q);
    end
    if (cmd_i.rev_init) begin
      lo_q <= '0;
      hi_q <= dc_m1[PTR_W-1:0];
    end
    if (cmd_i.xfer_init) begin
      idx_q <= '0;
    end
    unique case (cmd_i.mem_op)
      dlse_pkg::MEM_REV_RD_HI: tmp_q <= rd_data_q;
      dlse_pkg::MEM_REV_WR_HI: tmp_q <= rd_data_q;
      dlse_pkg::MEM_REV_WR_LO: begin
        lo_q <= lo_q + PTR_W'(1);
        hi_q <= hi_q - PTR_W'(1);
      end
      dlse_pkg::MEM_XFER_WR: idx_q <= idx_q + PTR_W'(1);
      default: tmp_q <= tmp_q;
    endcase
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_rv_q     <= res_rv_q;
      out_empty_q  <= (dc == '0);
      out_count_q  <= dlse_pkg::COUNT_W'(dc);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'b0000, out_count_q, out_empty_q, out_rv_q, out_status_q};

  // A finished result never overwrites one that still waits to be taken.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  // Stack counts never exceed the depth of a stack.
  a_cnt_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q[0]) <= dlse_pkg::DEPTH) && (32'(cnt_q[1]) <= dlse_pkg::DEPTH))
    else $error("stack count beyond depth");

  // The reverse walk only swaps while the pointers have not crossed.
  a_rev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_op == dlse_pkg::MEM_REV_RD_LO) |-> (lo_q < hi_q))
    else $error("reverse pointers crossed");

  // Bulk transfer writes stay inside the destination's effective capacity.
  a_xfer_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_op == dlse_pkg::MEM_XFER_WR) |-> (xfer_addr < dcap))
    else $error("transfer write beyond destination capacity");

  // A pop lowers the count by exactly one.
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_dec |=> (cnt_q[op_sel_q] == $past(dc_m1)))
    else $error("pop did not decrement the count");

endmodule

`default_nettype wire

[rtl/dual_lifo_stack_engine_core.sv]
// Dual LIFO stack engine top, joining dlse_ctrl and dlse_datapath. Push, clear and failed ops
// go from decide to done; pop and top add a read wait, move-top a write, reverse reads low and
// high then writes high and low per pair, append or overturn reads and writes each element.
// The next item enters as a result leaves, so an item holds the engine until its result moves
// out. The memory serves one access a cycle with registered read data, and a result waiting
// on m_axis_tready holds off the input. Reset empties both stacks, caps 256.
`default_nettype none

module dual_lifo_stack_engine_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration: index 0 capacity_first, index 1 capacity_second.
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [dlse_pkg::CAP_W-1:0]     cfg_wdata_i,
  // Input stream.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: push_value [31:0]
  input  wire logic [dlse_pkg::VALUE_W-1:0]   s_axis_tdata_i,
  // tuser: func [2:0], stack_sel [3]
  input  wire logic [dlse_pkg::IN_USER_W-1:0] s_axis_tuser_i,
  // Output stream.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata: status [1:0], read_value [33:2], target_empty [34],
  //        target_count [43:35], zero fill [47:44]
  output logic [dlse_pkg::OUT_W-1:0]          m_axis_tdata_o
);

  dlse_pkg::cmd_t  cmd;
  dlse_pkg::stat_t stat;

  // Operation sequencer.
  dlse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Memory, counts and result register.
  dlse_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
